/* rtl/iar_pkg.sv */
`timescale 1ns / 1ps
package iar_pkg;

    // kind of work the back end has to do for one item
    typedef enum logic [1:0] {
        KIND_DIGITS,
        KIND_ZERO,
        KIND_BAD
    } t_kind;

    // classified item passed from front to back
    typedef struct packed {
        t_kind      kind;
        logic       neg;
        logic [5:0] mag;
    } t_cmd;

    // one character result
    typedef struct packed {
        logic [7:0] char_code;
        logic       negative;
        logic       bad_radix;
        logic       last;
    } t_res;

    // legal radix magnitudes
    localparam logic [6:0] RADIX_MIN = 7'd2;
    localparam logic [6:0] RADIX_MAX = 7'd36;

    // ascii codes
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;

    // queue depths
    localparam int CMDQ_DEPTH = 2;
    localparam int OQ_DEPTH   = 4;

endpackage

/* rtl/iar_ram.sv */
`timescale 1ns / 1ps
module iar_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/iar_front.sv */
`timescale 1ns / 1ps
module iar_front #(
    parameter int VALUE_BITS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic [63:0]           i_value,
    input  logic signed [6:0]     i_radix,
    output logic                  o_cmd_valid,
    input  logic                  i_cmd_ready,
    output iar_pkg::t_cmd         o_cmd,
    output logic [VALUE_BITS-1:0] o_cmd_value
);
    import iar_pkg::*;

    localparam int PW = $clog2(CMDQ_DEPTH);
    localparam int CW = $clog2(CMDQ_DEPTH + 1);

    logic [VALUE_BITS-1:0] w_val;
    logic [VALUE_BITS-1:0] w_mag_val;
    logic [6:0]            w_rmag;
    logic                  w_signed;
    logic                  w_neg;
    logic                  w_bad;
    t_cmd                  w_cmd;
    logic                  w_push_xfer;
    logic                  w_pop_xfer;

    logic [VALUE_BITS-1:0] r_q_val [CMDQ_DEPTH];
    t_cmd                  r_q_cmd [CMDQ_DEPTH];
    logic [PW-1:0]         r_wr_ptr;
    logic [PW-1:0]         r_rd_ptr;
    logic [CW-1:0]         r_count;

    // classify the incoming item
    assign w_val     = i_value[VALUE_BITS-1:0];
    assign w_signed  = i_radix[6];
    assign w_rmag    = w_signed ? (7'd0 - $unsigned(i_radix)) : $unsigned(i_radix);
    assign w_bad     = (w_rmag < RADIX_MIN) || (w_rmag > RADIX_MAX);
    assign w_neg     = w_signed && w_val[VALUE_BITS-1];
    assign w_mag_val = w_neg ? ('0 - w_val) : w_val;

    always_comb begin
        w_cmd.mag = w_rmag[5:0];
        if (w_val == '0) begin
            w_cmd.kind = KIND_ZERO;
            w_cmd.neg  = 1'b0;
        end else if (w_bad) begin
            w_cmd.kind = KIND_BAD;
            w_cmd.neg  = 1'b0;
        end else begin
            w_cmd.kind = KIND_DIGITS;
            w_cmd.neg  = w_neg;
        end
    end

    // command queue handshakes
    assign o_full      = (r_count == CW'(CMDQ_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign w_push_xfer = i_push && !o_full;
    assign w_pop_xfer  = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q_cmd[r_rd_ptr];
    assign o_cmd_value = r_q_val[r_rd_ptr];

    // queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push_xfer) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop_xfer) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CW'(w_push_xfer) - CW'(w_pop_xfer);
        end
    end

    // queue payload
    always_ff @(posedge i_clk) begin
        if (w_push_xfer) begin
            r_q_cmd[r_wr_ptr] <= w_cmd;
            r_q_val[r_wr_ptr] <= w_mag_val;
        end
    end

endmodule

/* rtl/iar_conv.sv */
`timescale 1ns / 1ps
module iar_conv #(
    parameter int VALUE_BITS  = 64,
    parameter int DIGIT_SLOTS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_valid,
    output logic                  o_cmd_ready,
    input  iar_pkg::t_cmd         i_cmd,
    input  logic [VALUE_BITS-1:0] i_cmd_value,
    output logic                  o_empty,
    input  logic                  i_pop,
    output iar_pkg::t_res         o_res
);
    import iar_pkg::*;

    localparam int BYTES     = (VALUE_BITS + 7) / 8;
    localparam int WORK_BITS = BYTES * 8;
    localparam int BYTE_IW   = (BYTES > 1) ? $clog2(BYTES) : 1;
    localparam int AW        = $clog2(DIGIT_SLOTS);
    localparam int CW        = $clog2(DIGIT_SLOTS + 1);
    localparam int OQ_PW     = $clog2(OQ_DEPTH);
    localparam int OQ_CW     = $clog2(OQ_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ONE,
        S_DIV,
        S_EMIT
    } t_state;

    // eight restoring division steps on one byte; returns {remainder, quotient byte}
    function automatic logic [13:0] div_byte(input logic [5:0] rem_in,
                                             input logic [7:0] byte_in,
                                             input logic [5:0] mag);
        logic [6:0] t;
        logic [5:0] r;
        logic [7:0] q;
        r = rem_in;
        q = '0;
        for (int b = 7; b >= 0; b--) begin
            t = {r, byte_in[b]};
            if (t >= {1'b0, mag}) begin
                t    = t - {1'b0, mag};
                q[b] = 1'b1;
            end
            r = t[5:0];
        end
        return {r, q};
    endfunction

    // digit value to ascii
    function automatic logic [7:0] digit_char(input logic [5:0] d);
        if (d < 6'd10) begin
            return CHAR_ZERO + {2'b00, d};
        end
        return CHAR_UPPER_A + {2'b00, d} - 8'd10;
    endfunction

    t_state                r_state;
    logic [WORK_BITS-1:0]  r_work;
    logic [BYTE_IW-1:0]    r_pos;
    logic [BYTE_IW-1:0]    r_top;
    logic [5:0]            r_rem;
    logic [5:0]            r_mag;
    logic                  r_neg;
    t_kind                 r_kind;
    logic [CW-1:0]         r_n;
    logic [AW-1:0]         r_idx;
    logic                  r_rd_valid;
    logic                  r_rd_last;

    t_res                  r_oq [OQ_DEPTH];
    logic [OQ_PW-1:0]      r_oq_wr;
    logic [OQ_PW-1:0]      r_oq_rd;
    logic [OQ_CW-1:0]      r_oq_cnt;

    logic [7:0]            w_in_byte;
    logic [7:0]            w_q_byte;
    logic [5:0]            w_rem_next;
    logic [WORK_BITS-1:0]  n_work;
    logic                  w_q_zero;
    logic                  w_top_zero;
    logic                  w_store;
    logic [CW-1:0]         w_n_next;
    logic                  w_room;
    logic                  w_issue;
    logic                  w_we;
    logic [5:0]            w_rdata;
    logic                  w_oq_push;
    logic                  w_oq_pop;
    t_res                  w_oq_data;

    // one byte of the long division per cycle
    assign w_in_byte               = r_work[r_pos*8 +: 8];
    assign {w_rem_next, w_q_byte}  = div_byte(r_rem, w_in_byte, r_mag);

    always_comb begin
        n_work                = r_work;
        n_work[r_pos*8 +: 8]  = w_q_byte;
    end

    assign w_q_zero   = (n_work == '0);
    assign w_top_zero = (n_work[r_top*8 +: 8] == 8'd0);
    assign w_store    = (r_n < CW'(DIGIT_SLOTS));
    assign w_n_next   = w_store ? (r_n + 1'b1) : r_n;

    // result queue space, counting a read still in flight
    assign w_room  = ((r_oq_cnt + OQ_CW'(r_rd_valid)) < OQ_CW'(OQ_DEPTH));
    assign w_issue = (r_state == S_EMIT) && w_room;
    assign w_we    = (r_state == S_DIV) && (r_pos == '0) && w_store;

    assign o_cmd_ready = (r_state == S_IDLE);

    // digit store, least significant digit first
    iar_ram #(
        .WIDTH (6),
        .DEPTH (DIGIT_SLOTS)
    ) u_digits (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_n[AW-1:0]),
        .i_wdata (w_rem_next),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    // conversion sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= w_issue;
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_mag  <= i_cmd.mag;
                        r_neg  <= i_cmd.neg;
                        r_kind <= i_cmd.kind;
                        r_work <= WORK_BITS'(i_cmd_value);
                        r_pos  <= BYTE_IW'(BYTES - 1);
                        r_top  <= BYTE_IW'(BYTES - 1);
                        r_rem  <= '0;
                        r_n    <= '0;
                        if (i_cmd.kind == KIND_DIGITS) begin
                            r_state <= S_DIV;
                        end else begin
                            r_state <= S_ONE;
                        end
                    end
                end
                S_ONE: begin
                    if (w_room) begin
                        r_state <= S_IDLE;
                    end
                end
                S_DIV: begin
                    r_work <= n_work;
                    if (r_pos == '0) begin
                        // one digit done
                        r_n   <= w_n_next;
                        r_rem <= '0;
                        if (w_q_zero) begin
                            r_idx   <= AW'(w_n_next - 1'b1);
                            r_state <= S_EMIT;
                        end else if (w_top_zero && (r_top != '0)) begin
                            r_top <= r_top - 1'b1;
                            r_pos <= r_top - 1'b1;
                        end else begin
                            r_pos <= r_top;
                        end
                    end else begin
                        r_pos <= r_pos - 1'b1;
                        r_rem <= w_rem_next;
                    end
                end
                S_EMIT: begin
                    if (w_room) begin
                        r_rd_last <= (r_idx == '0);
                        if (r_idx == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx <= r_idx - 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result queue input: digit reads and single special results never coincide
    always_comb begin
        if (r_rd_valid) begin
            w_oq_data.char_code = digit_char(w_rdata);
            w_oq_data.negative  = r_neg;
            w_oq_data.bad_radix = 1'b0;
            w_oq_data.last      = r_rd_last;
        end else begin
            w_oq_data.char_code = (r_kind == KIND_ZERO) ? CHAR_ZERO : 8'd0;
            w_oq_data.negative  = 1'b0;
            w_oq_data.bad_radix = (r_kind == KIND_BAD);
            w_oq_data.last      = 1'b1;
        end
    end

    assign w_oq_push = r_rd_valid || ((r_state == S_ONE) && w_room);
    assign o_empty   = (r_oq_cnt == '0);
    assign w_oq_pop  = i_pop && !o_empty;
    assign o_res     = r_oq[r_oq_rd];

    // result queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wr  <= '0;
            r_oq_rd  <= '0;
            r_oq_cnt <= '0;
        end else begin
            if (w_oq_push) begin
                r_oq_wr <= r_oq_wr + 1'b1;
            end
            if (w_oq_pop) begin
                r_oq_rd <= r_oq_rd + 1'b1;
            end
            r_oq_cnt <= r_oq_cnt + OQ_CW'(w_oq_push) - OQ_CW'(w_oq_pop);
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (w_oq_push) begin
            r_oq[r_oq_wr] <= w_oq_data;
        end
    end

endmodule

/* rtl/integer_to_ascii_radix.sv */
`timescale 1ns / 1ps
// channel   direction  transfer when        payload
// input     in         push & !full         i_value, i_radix
// result    out        pop & !empty         o_char_code, o_negative, o_bad_radix, o_last
//
// Each digit divides the working quotient a byte at a time (8 division steps per byte); the
// width starts at the full value and drops a byte per digit once its top byte is clear.
// A value is divided down to its digits, least significant first, then the block
// emits one character a cycle, most significant first, while the result queue has room.
// Zero and bad radix items give their single result without any division.
// Synchronous reset clears both queues and the sequencer; a two-entry queue decouples stalls.
module integer_to_ascii_radix #(
    parameter int DIGIT_SLOTS = 64,
    parameter int VALUE_BITS  = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [63:0]       i_value,
    input  logic signed [6:0] i_radix,
    output logic              empty,
    input  logic              pop,
    output logic [7:0]        o_char_code,
    output logic              o_negative,
    output logic              o_bad_radix,
    output logic              o_last
);
    import iar_pkg::*;

    logic                  w_cmd_valid;
    logic                  w_cmd_ready;
    t_cmd                  w_cmd;
    logic [VALUE_BITS-1:0] w_cmd_value;
    t_res                  w_res;

    // front end: classify and queue
    iar_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_value     (i_value),
        .i_radix     (i_radix),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready),
        .o_cmd       (w_cmd),
        .o_cmd_value (w_cmd_value)
    );

    // back end: divide, store digits, emit
    iar_conv #(
        .VALUE_BITS  (VALUE_BITS),
        .DIGIT_SLOTS (DIGIT_SLOTS)
    ) u_conv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .i_cmd_value (w_cmd_value),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_res       (w_res)
    );

    assign o_char_code = w_res.char_code;
    assign o_negative  = w_res.negative;
    assign o_bad_radix = w_res.bad_radix;
    assign o_last      = w_res.last;

    // result queue comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> empty)
        else $error("result queue not empty after reset");

    // error result carries no character and closes the run
    a_bad_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_bad_radix) |-> (o_char_code == 8'd0 && o_last && !o_negative))
        else $error("bad radix result with wrong fields");

    // every other result is a digit character
    a_digit_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_bad_radix) |->
            ((o_char_code >= CHAR_ZERO && o_char_code <= CHAR_NINE) ||
             (o_char_code >= CHAR_UPPER_A && o_char_code <= CHAR_UPPER_Z)))
        else $error("result is not a digit character");

    // a full front queue always offers work to the back end
    a_full_offers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> w_cmd_valid)
        else $error("front queue full but no command offered");

endmodule
